// ----- hw/rtl/smrs_pkg.sv -----
// ----------------------------------------------------------------------------
// smrs_pkg
// Shared widths, operation codes, statistic numbers and stage types of the
// sparse matrix row statistics block.
// ----------------------------------------------------------------------------
package smrs_pkg;

  localparam int IDX_W  = 20;  // row and column index
  localparam int LEN_W  = 21;  // row lengths and row counters
  localparam int CNT_W  = 48;  // non-zero counters
  localparam int VAL_W  = 32;  // Q16.16 value
  localparam int SUM_W  = VAL_W + 8;  // off-diagonal magnitude sum
  localparam int DISC_W = VAL_W + 9;  // disc bounds
  localparam int SEL_W  = 5;
  localparam int STAT_W = 64;

  localparam logic [LEN_W-1:0] MAX_COLUMNS = LEN_W'(1) << IDX_W;
  localparam logic [LEN_W-1:0] LEN_MAX     = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MIN_RESET = MAX_COLUMNS + LEN_W'(1);

  localparam logic [VAL_W-1:0]  VAL_POS  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]  VAL_NEG  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0]  MAG_INIT = {VAL_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [DISC_W-1:0] DISC_POS = {1'b0, {(DISC_W-1){1'b1}}};
  localparam logic [DISC_W-1:0] DISC_NEG = {1'b1, {(DISC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ENTRY     = 2'd0,
    OP_EMPTY_ROW = 2'd1,
    OP_READ      = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  localparam logic [SEL_W-1:0] ST_NZ_TOTAL      = 5'd0;
  localparam logic [SEL_W-1:0] ST_NZ_LEFT       = 5'd1;
  localparam logic [SEL_W-1:0] ST_NZ_RIGHT      = 5'd2;
  localparam logic [SEL_W-1:0] ST_ROW_LEN_MIN   = 5'd3;
  localparam logic [SEL_W-1:0] ST_ROW_LEN_MAX   = 5'd4;
  localparam logic [SEL_W-1:0] ST_ROW_LEFT_MAX  = 5'd5;
  localparam logic [SEL_W-1:0] ST_ROW_RIGHT_MAX = 5'd6;
  localparam logic [SEL_W-1:0] ST_EMPTY_ROWS    = 5'd7;
  localparam logic [SEL_W-1:0] ST_MISSING_DIAG  = 5'd8;
  localparam logic [SEL_W-1:0] ST_BAND_LEFT     = 5'd9;
  localparam logic [SEL_W-1:0] ST_BAND_RIGHT    = 5'd10;
  localparam logic [SEL_W-1:0] ST_VALUE_MIN     = 5'd11;
  localparam logic [SEL_W-1:0] ST_VALUE_MAX     = 5'd12;
  localparam logic [SEL_W-1:0] ST_SMALLEST_MAG  = 5'd13;
  localparam logic [SEL_W-1:0] ST_DIAG_MIN      = 5'd14;
  localparam logic [SEL_W-1:0] ST_DIAG_MAX      = 5'd15;
  localparam logic [SEL_W-1:0] ST_DIAG_MAG      = 5'd16;
  localparam logic [SEL_W-1:0] ST_DISC_LOW      = 5'd17;
  localparam logic [SEL_W-1:0] ST_DISC_HIGH     = 5'd18;
  localparam logic [SEL_W-1:0] ST_BANDWIDTH     = 5'd19;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
    logic [VAL_W-1:0] value;
    logic             last_in_row;
    logic [SEL_W-1:0] stat_select;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic              valid;
    logic [SEL_W-1:0]  stat_id;
    logic [STAT_W-1:0] stat_value;
  } result_t;

endpackage

// ----- hw/rtl/smrs_in_if.sv -----
// ----------------------------------------------------------------------------
// smrs_in_if
// Input item channel: operation, indices, value, row end mark, selection.
// ----------------------------------------------------------------------------
interface smrs_in_if;
  import smrs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        column_index;
  logic signed [VAL_W-1:0] value;
  logic                    last_in_row;
  logic [SEL_W-1:0]        stat_select;

  modport source (
    output valid, operation, row_index, column_index, value, last_in_row, stat_select,
    input  ready
  );
  modport sink (
    input  valid, operation, row_index, column_index, value, last_in_row, stat_select,
    output ready
  );
endinterface

// ----- hw/rtl/smrs_out_if.sv -----
// ----------------------------------------------------------------------------
// smrs_out_if
// Result item channel: statistic number and its value.
// ----------------------------------------------------------------------------
interface smrs_out_if;
  import smrs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SEL_W-1:0]         stat_id;
  logic signed [STAT_W-1:0] stat_value;

  modport source (output valid, stat_id, stat_value, input ready);
  modport sink (input valid, stat_id, stat_value, output ready);
endinterface

// ----- hw/rtl/smrs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// smrs_cfg_if
// Configuration write channel for the column count register.
// ----------------------------------------------------------------------------
interface smrs_cfg_if;
  import smrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/smrs_in_stage.sv -----
// ----------------------------------------------------------------------------
// smrs_in_stage
// Input register. Holds one item until the statistics core takes it.
// ----------------------------------------------------------------------------
module smrs_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  smrs_in_if.sink         in_ch,
  input  logic            fire,
  output smrs_pkg::stage_t s1
);
  import smrs_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // A held item that fires this cycle frees the register for the next one.
  assign in_ch.ready = !valid_r || fire;
  assign accept      = in_ch.valid && in_ch.ready;
  assign valid_nxt   = accept || (valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.operation    <= op_t'(in_ch.operation);
      item_r.row_index    <= in_ch.row_index;
      item_r.column_index <= in_ch.column_index;
      item_r.value        <= in_ch.value;
      item_r.last_in_row  <= in_ch.last_in_row;
      item_r.stat_select  <= in_ch.stat_select;
    end
  end

  assign s1.valid = valid_r;
  assign s1.item  = item_r;

endmodule

// ----- hw/rtl/smrs_core.sv -----
// ----------------------------------------------------------------------------
// smrs_core
// Statistics registers, their update and the read selection.
// Disc bounds of a closed row fold in the cycle after through a pending
// register; reads see the folded value at once.
// ----------------------------------------------------------------------------
module smrs_core (
  input  logic              clk,
  input  logic              rst_n,
  smrs_cfg_if.sink          cfg_ch,
  input  smrs_pkg::stage_t  s1,
  input  logic              out_can,
  output logic              fire,
  output smrs_pkg::result_t res
);
  import smrs_pkg::*;

  function automatic logic [LEN_W-1:0] inc_len(input logic [LEN_W-1:0] x);
    return (x == LEN_MAX) ? LEN_MAX : x + LEN_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] x);
    return (x == CNT_MAX) ? CNT_MAX : x + CNT_W'(1);
  endfunction

  localparam logic signed [DISC_W:0] LIM_HI = {2'b00, {SUM_W{1'b1}}};
  localparam logic signed [DISC_W:0] LIM_LO = {2'b11, {SUM_W{1'b0}}};

  // Configuration.
  logic [LEN_W-1:0] col_cnt_r;
  logic [LEN_W-1:0] len_seed;

  // Statistics.
  logic [CNT_W-1:0]         nz_total_r, nz_total_nxt;
  logic [CNT_W-1:0]         nz_left_r, nz_left_nxt;
  logic [CNT_W-1:0]         nz_right_r, nz_right_nxt;
  logic [LEN_W-1:0]         row_len_min_r, row_len_min_nxt;
  logic [LEN_W-1:0]         row_len_max_r, row_len_max_nxt;
  logic [LEN_W-1:0]         row_left_max_r, row_left_max_nxt;
  logic [LEN_W-1:0]         row_right_max_r, row_right_max_nxt;
  logic [LEN_W-1:0]         empty_rows_r, empty_rows_nxt;
  logic [LEN_W-1:0]         missing_diag_r, missing_diag_nxt;
  logic [IDX_W-1:0]         band_left_r, band_left_nxt;
  logic [IDX_W-1:0]         band_right_r, band_right_nxt;
  logic signed [VAL_W-1:0]  value_min_r, value_min_nxt;
  logic signed [VAL_W-1:0]  value_max_r, value_max_nxt;
  logic [VAL_W-1:0]         small_mag_r, small_mag_nxt;
  logic signed [VAL_W-1:0]  diag_min_r, diag_min_nxt;
  logic signed [VAL_W-1:0]  diag_max_r, diag_max_nxt;
  logic [VAL_W-1:0]         diag_mag_r, diag_mag_nxt;
  logic signed [DISC_W-1:0] disc_low_r, disc_low_nxt;
  logic signed [DISC_W-1:0] disc_high_r, disc_high_nxt;

  // Open row accumulators.
  logic [LEN_W-1:0]         cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0]         cur_left_r, cur_left_nxt;
  logic [LEN_W-1:0]         cur_right_r, cur_right_nxt;
  logic                     cur_seen_r, cur_seen_nxt;
  logic signed [VAL_W-1:0]  cur_diag_r, cur_diag_nxt;
  logic [SUM_W-1:0]         cur_sum_r, cur_sum_nxt;

  // Row closed in the previous cycle, waiting to fold into the disc bounds.
  logic                     pend_valid_r, pend_valid_nxt;
  logic signed [VAL_W-1:0]  pend_d_r, pend_d_nxt;
  logic [SUM_W-1:0]         pend_s_r, pend_s_nxt;

  // Item decode.
  logic                    is_entry, is_empty, is_read, is_clear, do_close;
  logic signed [VAL_W-1:0] val_s;
  logic [VAL_W-1:0]        mag;
  logic                    val_nz, col_left, col_right, col_diag;
  logic [IDX_W-1:0]        dist_left, dist_right;
  logic [SUM_W:0]          sum_add;
  logic [LEN_W-1:0]        len_new, left_new, right_new;
  logic                    seen_new;
  logic signed [VAL_W-1:0] diag_new;
  logic [SUM_W-1:0]        sum_new;
  logic [LEN_W-1:0]        cl_len, cl_left, cl_right;
  logic                    cl_seen;

  // Disc fold.
  logic signed [DISC_W:0]   disc_lo_raw, disc_hi_raw;
  logic signed [DISC_W-1:0] disc_lo, disc_hi;
  logic signed [DISC_W-1:0] disc_low_eff, disc_high_eff;

  logic [STAT_W-1:0] rd_value;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= MAX_COLUMNS;
    end else if (cfg_ch.valid) begin
      col_cnt_r <= cfg_ch.data;
    end
  end

  assign len_seed = ((col_cnt_r > MAX_COLUMNS) ? MAX_COLUMNS : col_cnt_r) + LEN_W'(1);

  // Reads need the output register; everything else goes through at once.
  assign fire = s1.valid && (s1.item.operation != OP_READ || out_can);

  always_comb begin
    is_entry = 1'b0;
    is_empty = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    unique case (s1.item.operation)
      OP_ENTRY:     is_entry = fire;
      OP_EMPTY_ROW: is_empty = fire;
      OP_READ:      is_read  = fire;
      OP_CLEAR:     is_clear = fire;
    endcase
  end

  assign val_s     = $signed(s1.item.value);
  assign mag       = val_s[VAL_W-1] ? (~s1.item.value + VAL_W'(1)) : s1.item.value;
  assign val_nz    = (s1.item.value != '0);
  assign col_left  = (s1.item.column_index < s1.item.row_index);
  assign col_right = (s1.item.column_index > s1.item.row_index);
  assign col_diag  = (s1.item.column_index == s1.item.row_index);
  assign dist_left  = s1.item.row_index - s1.item.column_index;
  assign dist_right = s1.item.column_index - s1.item.row_index;

  // Row accumulators including the current entry.
  assign sum_add   = {1'b0, cur_sum_r} + {{(SUM_W+1-VAL_W){1'b0}}, mag};
  assign len_new   = inc_len(cur_len_r);
  assign left_new  = col_left ? inc_len(cur_left_r) : cur_left_r;
  assign right_new = col_right ? inc_len(cur_right_r) : cur_right_r;
  assign seen_new  = cur_seen_r || col_diag;
  assign diag_new  = col_diag ? val_s : cur_diag_r;
  assign sum_new   = col_diag ? cur_sum_r : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);

  // An empty row closes a row of length zero and leaves the open row alone.
  assign do_close = is_empty || (is_entry && s1.item.last_in_row);
  assign cl_len   = is_empty ? '0 : len_new;
  assign cl_left  = is_empty ? '0 : left_new;
  assign cl_right = is_empty ? '0 : right_new;
  assign cl_seen  = is_empty ? 1'b0 : seen_new;

  assign disc_lo_raw = $signed({{(DISC_W+1-VAL_W){pend_d_r[VAL_W-1]}}, pend_d_r}
                       - {{(DISC_W+1-SUM_W){1'b0}}, pend_s_r});
  assign disc_hi_raw = $signed({{(DISC_W+1-VAL_W){pend_d_r[VAL_W-1]}}, pend_d_r}
                       + {{(DISC_W+1-SUM_W){1'b0}}, pend_s_r});

  always_comb begin
    if (disc_lo_raw > LIM_HI) begin
      disc_lo = DISC_POS;
    end else if (disc_lo_raw < LIM_LO) begin
      disc_lo = DISC_NEG;
    end else begin
      disc_lo = disc_lo_raw[DISC_W-1:0];
    end
    if (disc_hi_raw > LIM_HI) begin
      disc_hi = DISC_POS;
    end else if (disc_hi_raw < LIM_LO) begin
      disc_hi = DISC_NEG;
    end else begin
      disc_hi = disc_hi_raw[DISC_W-1:0];
    end
  end

  assign disc_low_eff  = (pend_valid_r && disc_lo < disc_low_r) ? disc_lo : disc_low_r;
  assign disc_high_eff = (pend_valid_r && disc_hi > disc_high_r) ? disc_hi : disc_high_r;

  always_comb begin
    nz_total_r_hold: begin end
    nz_total_nxt      = nz_total_r;
    nz_left_nxt       = nz_left_r;
    nz_right_nxt      = nz_right_r;
    row_len_min_nxt   = row_len_min_r;
    row_len_max_nxt   = row_len_max_r;
    row_left_max_nxt  = row_left_max_r;
    row_right_max_nxt = row_right_max_r;
    empty_rows_nxt    = empty_rows_r;
    missing_diag_nxt  = missing_diag_r;
    band_left_nxt     = band_left_r;
    band_right_nxt    = band_right_r;
    value_min_nxt     = value_min_r;
    value_max_nxt     = value_max_r;
    small_mag_nxt     = small_mag_r;
    diag_min_nxt      = diag_min_r;
    diag_max_nxt      = diag_max_r;
    diag_mag_nxt      = diag_mag_r;
    disc_low_nxt      = disc_low_eff;
    disc_high_nxt     = disc_high_eff;
    cur_len_nxt       = cur_len_r;
    cur_left_nxt      = cur_left_r;
    cur_right_nxt     = cur_right_r;
    cur_seen_nxt      = cur_seen_r;
    cur_diag_nxt      = cur_diag_r;
    cur_sum_nxt       = cur_sum_r;
    pend_valid_nxt    = 1'b0;
    pend_d_nxt        = pend_d_r;
    pend_s_nxt        = pend_s_r;

    if (is_clear) begin
      nz_total_nxt      = '0;
      nz_left_nxt       = '0;
      nz_right_nxt      = '0;
      row_len_min_nxt   = len_seed;
      row_len_max_nxt   = '0;
      row_left_max_nxt  = '0;
      row_right_max_nxt = '0;
      empty_rows_nxt    = '0;
      missing_diag_nxt  = '0;
      band_left_nxt     = '0;
      band_right_nxt    = '0;
      value_min_nxt     = VAL_POS;
      value_max_nxt     = VAL_NEG;
      small_mag_nxt     = MAG_INIT;
      diag_min_nxt      = VAL_POS;
      diag_max_nxt      = VAL_NEG;
      diag_mag_nxt      = MAG_INIT;
      disc_low_nxt      = DISC_POS;
      disc_high_nxt     = DISC_NEG;
      cur_len_nxt       = '0;
      cur_left_nxt      = '0;
      cur_right_nxt     = '0;
      cur_seen_nxt      = 1'b0;
      cur_diag_nxt      = '0;
      cur_sum_nxt       = '0;
    end else begin
      if (is_entry) begin
        nz_total_nxt = inc_cnt(nz_total_r);
        if (col_left) begin
          nz_left_nxt = inc_cnt(nz_left_r);
          if (dist_left > band_left_r) begin
            band_left_nxt = dist_left;
          end
        end
        if (col_right) begin
          nz_right_nxt = inc_cnt(nz_right_r);
          if (dist_right > band_right_r) begin
            band_right_nxt = dist_right;
          end
        end
        if (val_s < value_min_r) begin
          value_min_nxt = val_s;
        end
        if (val_s > value_max_r) begin
          value_max_nxt = val_s;
        end
        if (val_nz && mag < small_mag_r) begin
          small_mag_nxt = mag;
        end
        if (col_diag) begin
          if (val_s < diag_min_r) begin
            diag_min_nxt = val_s;
          end
          if (val_s > diag_max_r) begin
            diag_max_nxt = val_s;
          end
          if (val_nz && mag < diag_mag_r) begin
            diag_mag_nxt = mag;
          end
        end
        if (s1.item.last_in_row) begin
          cur_len_nxt   = '0;
          cur_left_nxt  = '0;
          cur_right_nxt = '0;
          cur_seen_nxt  = 1'b0;
          cur_diag_nxt  = '0;
          cur_sum_nxt   = '0;
        end else begin
          cur_len_nxt   = len_new;
          cur_left_nxt  = left_new;
          cur_right_nxt = right_new;
          cur_seen_nxt  = seen_new;
          cur_diag_nxt  = diag_new;
          cur_sum_nxt   = sum_new;
        end
      end
      if (do_close) begin
        if (cl_len < row_len_min_r) begin
          row_len_min_nxt = cl_len;
        end
        if (cl_len > row_len_max_r) begin
          row_len_max_nxt = cl_len;
        end
        if (cl_left > row_left_max_r) begin
          row_left_max_nxt = cl_left;
        end
        if (cl_right > row_right_max_r) begin
          row_right_max_nxt = cl_right;
        end
        if (cl_len == '0) begin
          empty_rows_nxt = inc_len(empty_rows_r);
        end
        // A row without a diagonal entry counts its diagonal as zero.
        if (!cl_seen) begin
          missing_diag_nxt = inc_len(missing_diag_r);
          if (!diag_min_nxt[VAL_W-1]) begin
            diag_min_nxt = '0;
          end
          if (diag_max_nxt[VAL_W-1]) begin
            diag_max_nxt = '0;
          end
          diag_mag_nxt = '0;
        end
        pend_valid_nxt = 1'b1;
        pend_d_nxt     = cl_seen ? diag_new : '0;
        pend_s_nxt     = is_empty ? '0 : sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_total_r      <= '0;
      nz_left_r       <= '0;
      nz_right_r      <= '0;
      row_len_min_r   <= LEN_MIN_RESET;
      row_len_max_r   <= '0;
      row_left_max_r  <= '0;
      row_right_max_r <= '0;
      empty_rows_r    <= '0;
      missing_diag_r  <= '0;
      band_left_r     <= '0;
      band_right_r    <= '0;
      value_min_r     <= VAL_POS;
      value_max_r     <= VAL_NEG;
      small_mag_r     <= MAG_INIT;
      diag_min_r      <= VAL_POS;
      diag_max_r      <= VAL_NEG;
      diag_mag_r      <= MAG_INIT;
      disc_low_r      <= DISC_POS;
      disc_high_r     <= DISC_NEG;
      cur_len_r       <= '0;
      cur_left_r      <= '0;
      cur_right_r     <= '0;
      cur_seen_r      <= 1'b0;
      cur_diag_r      <= '0;
      cur_sum_r       <= '0;
      pend_valid_r    <= 1'b0;
    end else begin
      nz_total_r      <= nz_total_nxt;
      nz_left_r       <= nz_left_nxt;
      nz_right_r      <= nz_right_nxt;
      row_len_min_r   <= row_len_min_nxt;
      row_len_max_r   <= row_len_max_nxt;
      row_left_max_r  <= row_left_max_nxt;
      row_right_max_r <= row_right_max_nxt;
      empty_rows_r    <= empty_rows_nxt;
      missing_diag_r  <= missing_diag_nxt;
      band_left_r     <= band_left_nxt;
      band_right_r    <= band_right_nxt;
      value_min_r     <= value_min_nxt;
      value_max_r     <= value_max_nxt;
      small_mag_r     <= small_mag_nxt;
      diag_min_r      <= diag_min_nxt;
      diag_max_r      <= diag_max_nxt;
      diag_mag_r      <= diag_mag_nxt;
      disc_low_r      <= disc_low_nxt;
      disc_high_r     <= disc_high_nxt;
      cur_len_r       <= cur_len_nxt;
      cur_left_r      <= cur_left_nxt;
      cur_right_r     <= cur_right_nxt;
      cur_seen_r      <= cur_seen_nxt;
      cur_diag_r      <= cur_diag_nxt;
      cur_sum_r       <= cur_sum_nxt;
      pend_valid_r    <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_d_r <= pend_d_nxt;
    pend_s_r <= pend_s_nxt;
  end

  always_comb begin
    unique case (s1.item.stat_select)
      ST_NZ_TOTAL:      rd_value = {{(STAT_W-CNT_W){1'b0}}, nz_total_r};
      ST_NZ_LEFT:       rd_value = {{(STAT_W-CNT_W){1'b0}}, nz_left_r};
      ST_NZ_RIGHT:      rd_value = {{(STAT_W-CNT_W){1'b0}}, nz_right_r};
      ST_ROW_LEN_MIN:   rd_value = {{(STAT_W-LEN_W){1'b0}}, row_len_min_r};
      ST_ROW_LEN_MAX:   rd_value = {{(STAT_W-LEN_W){1'b0}}, row_len_max_r};
      ST_ROW_LEFT_MAX:  rd_value = {{(STAT_W-LEN_W){1'b0}}, row_left_max_r};
      ST_ROW_RIGHT_MAX: rd_value = {{(STAT_W-LEN_W){1'b0}}, row_right_max_r};
      ST_EMPTY_ROWS:    rd_value = {{(STAT_W-LEN_W){1'b0}}, empty_rows_r};
      ST_MISSING_DIAG:  rd_value = {{(STAT_W-LEN_W){1'b0}}, missing_diag_r};
      ST_BAND_LEFT:     rd_value = {{(STAT_W-IDX_W){1'b0}}, band_left_r};
      ST_BAND_RIGHT:    rd_value = {{(STAT_W-IDX_W){1'b0}}, band_right_r};
      ST_VALUE_MIN:     rd_value = {{(STAT_W-VAL_W){value_min_r[VAL_W-1]}}, value_min_r};
      ST_VALUE_MAX:     rd_value = {{(STAT_W-VAL_W){value_max_r[VAL_W-1]}}, value_max_r};
      ST_SMALLEST_MAG:  rd_value = {{(STAT_W-VAL_W){1'b0}}, small_mag_r};
      ST_DIAG_MIN:      rd_value = {{(STAT_W-VAL_W){diag_min_r[VAL_W-1]}}, diag_min_r};
      ST_DIAG_MAX:      rd_value = {{(STAT_W-VAL_W){diag_max_r[VAL_W-1]}}, diag_max_r};
      ST_DIAG_MAG:      rd_value = {{(STAT_W-VAL_W){1'b0}}, diag_mag_r};
      ST_DISC_LOW:      rd_value = {{(STAT_W-DISC_W){disc_low_eff[DISC_W-1]}}, disc_low_eff};
      ST_DISC_HIGH:     rd_value = {{(STAT_W-DISC_W){disc_high_eff[DISC_W-1]}}, disc_high_eff};
      ST_BANDWIDTH:     rd_value = {{(STAT_W-IDX_W){1'b0}},
                                    (band_left_r > band_right_r) ? band_left_r : band_right_r};
      default:          rd_value = '0;
    endcase
  end

  assign res.valid      = is_read;
  assign res.stat_id    = s1.item.stat_select;
  assign res.stat_value = rd_value;

`ifndef SYNTHESIS
  // Every left or right entry also counts in the total, which saturates first.
  a_total_covers_sides: assert property (@(posedge clk) disable iff (!rst_n)
    nz_total_r >= nz_left_r && nz_total_r >= nz_right_r)
    else $error("non-zero total below a side count");

  a_row_covers_sides: assert property (@(posedge clk) disable iff (!rst_n)
    cur_len_r >= cur_left_r && cur_len_r >= cur_right_r)
    else $error("open row length below a side count");

  a_pending_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> $past(do_close))
    else $error("disc fold pending without a row close");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    is_clear |=> nz_total_r == '0 && !pend_valid_r && cur_len_r == '0
                 && disc_low_r == DISC_POS)
    else $error("clear left statistics behind");

  a_read_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_can)
    else $error("read result issued with the output register full");
`endif

endmodule

// ----- hw/rtl/smrs_out_stage.sv -----
// ----------------------------------------------------------------------------
// smrs_out_stage
// Result register between the statistics core and the result channel.
// ----------------------------------------------------------------------------
module smrs_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  smrs_pkg::result_t res,
  output logic              out_can,
  smrs_out_if.source        out_ch
);
  import smrs_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [SEL_W-1:0]  id_r;
  logic [STAT_W-1:0] value_r;

  // The register can take a new result when empty or emptying this cycle.
  assign out_can   = !valid_r || out_ch.ready;
  assign valid_nxt = res.valid || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      id_r    <= res.stat_id;
      value_r <= res.stat_value;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.stat_id    = id_r;
  assign out_ch.stat_value = value_r;

endmodule

// ----- hw/rtl/sparse_matrix_row_statistics.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_row_statistics
// Running statistics over a sparse matrix streamed row by row.
//
//   channel  direction  handshake      payload
//   in_ch    sink       valid/ready    operation, row_index, column_index,
//                                      value, last_in_row, stat_select
//   out_ch   source     valid/ready    stat_id, stat_value
//   cfg_ch   sink       valid/ready    data (column_count)
//
// One item is taken per cycle unless a read waits on a stalled out_ch;
// items pass the input register, and read results the output register.
// cfg_ch is always ready. Reset is synchronous and restores column_count
// and all statistics. A stalled out_ch holds back only reads; entries,
// empty rows and clears keep flowing past a waiting result.
// ----------------------------------------------------------------------------
module sparse_matrix_row_statistics (
  input  logic       clk,
  input  logic       rst_n,
  smrs_in_if.sink    in_ch,
  smrs_out_if.source out_ch,
  smrs_cfg_if.sink   cfg_ch
);
  import smrs_pkg::*;

  stage_t  s1;
  result_t res;
  logic    fire;
  logic    out_can;

  smrs_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .fire  (fire),
    .s1    (s1)
  );

  smrs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .s1      (s1),
    .out_can (out_can),
    .fire    (fire),
    .res     (res)
  );

  smrs_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .out_can (out_can),
    .out_ch  (out_ch)
  );

endmodule
